>>> rtl/core/fca_pkg.sv
package fca_pkg;

    // Color and bitmap geometry. A color is packed as blue<<16 | green<<8 | red.
    localparam int COLOR_W     = 24;
    localparam int BYTE_W      = 8;
    localparam int ROW_SEL_W   = 6;
    localparam int ROW_W       = 1 << ROW_SEL_W;
    localparam int ROW_ADDR_W  = COLOR_W - ROW_SEL_W;
    localparam int ROW_COUNT   = 1 << ROW_ADDR_W;

    // Step of the search cursor, modulo 2^COLOR_W.
    localparam logic [COLOR_W-1:0] CURSOR_STRIDE = COLOR_W'(97);

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    // Operation codes as they arrive on the input stream.
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_MARK  = 2'd1,
        OP_FIND  = 2'd2
    } op_t;

    // One classified command as it waits in the queue.
    typedef struct packed {
        op_t                op;
        logic [COLOR_W-1:0] color;
    } cmd_t;

    // States of the back-end sequencer.
    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_CHECK = 2'd2
    } eng_state_t;

endpackage

>>> rtl/core/fca_front.sv
module fca_front (
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [fca_pkg::COLOR_W-1:0]        s_tdata,   // red, green, blue
    input  logic [1:0]                         s_tuser,   // operation
    input  logic                               q_full,
    output logic                               q_push,
    output fca_pkg::cmd_t                      q_cmd
);

    logic known_op;

    // Requests are taken whenever the queue has room.
    assign s_tready = !q_full;

    // Sort out the operation; the unused code is taken and dropped.
    always_comb
    begin
        known_op = (s_tuser == fca_pkg::OP_CLEAR) || (s_tuser == fca_pkg::OP_MARK)
                || (s_tuser == fca_pkg::OP_FIND);
        q_push   = s_tvalid && !q_full && known_op;
        q_cmd.op = fca_pkg::op_t'(s_tuser);
        // Pack the color as blue<<16 | green<<8 | red.
        q_cmd.color = {s_tdata[fca_pkg::BYTE_W-1:0],
                       s_tdata[2*fca_pkg::BYTE_W-1:fca_pkg::BYTE_W],
                       s_tdata[3*fca_pkg::BYTE_W-1:2*fca_pkg::BYTE_W]};
    end

endmodule

>>> rtl/core/fca_queue.sv
module fca_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  fca_pkg::cmd_t   push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output fca_pkg::cmd_t   head_cmd
);

    fca_pkg::cmd_t                      entry_reg [fca_pkg::QUEUE_DEPTH];
    logic [fca_pkg::QUEUE_PTR_W-1:0]    wr_ptr_reg;
    logic [fca_pkg::QUEUE_PTR_W-1:0]    rd_ptr_reg;
    logic [fca_pkg::QUEUE_CNT_W-1:0]    count_reg;
    logic [fca_pkg::QUEUE_CNT_W-1:0]    count_next;

    assign full       = (count_reg == fca_pkg::QUEUE_CNT_W'(fca_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (push && !(pop && head_valid))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && pop && head_valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and occupancy.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && head_valid)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/core/fca_engine.sv
module fca_engine (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_valid,
    input  fca_pkg::cmd_t                   q_cmd,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fca_pkg::COLOR_W-1:0]     m_tdata,   // free_red, free_green, free_blue
    output logic                            m_tuser    // found
);

    localparam logic [fca_pkg::ROW_ADDR_W-1:0] LAST_ROW = '1;

    // Presence bitmap, one row of colors per word.
    logic [fca_pkg::ROW_W-1:0]          bitmap_mem [fca_pkg::ROW_COUNT];
    logic [fca_pkg::ROW_W-1:0]          rd_data_reg;

    fca_pkg::eng_state_t                state_reg;
    fca_pkg::eng_state_t                state_next;
    logic [fca_pkg::ROW_ADDR_W-1:0]     clr_cnt_reg;
    logic [fca_pkg::COLOR_W-1:0]        cursor_reg;
    logic [fca_pkg::COLOR_W-1:0]        start_reg;
    logic                               out_valid_reg;
    logic [fca_pkg::COLOR_W-1:0]        out_color_reg;
    logic                               out_found_reg;

    logic [fca_pkg::COLOR_W-1:0]        step_color;
    logic                               cur_used;
    logic                               wrapped;
    logic [fca_pkg::ROW_ADDR_W-1:0]     rd_addr;
    logic                               clr_we;
    logic                               mark_we;
    logic                               find_start;
    logic                               find_done;

    assign step_color = cursor_reg + fca_pkg::CURSOR_STRIDE;
    assign cur_used   = rd_data_reg[cursor_reg[fca_pkg::ROW_SEL_W-1:0]];
    assign wrapped    = (step_color == start_reg);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_color_reg[fca_pkg::BYTE_W-1:0],
                       out_color_reg[2*fca_pkg::BYTE_W-1:fca_pkg::BYTE_W],
                       out_color_reg[3*fca_pkg::BYTE_W-1:2*fca_pkg::BYTE_W]};
    assign m_tuser  = out_found_reg;

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fca_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == LAST_ROW)
                begin
                    state_next = fca_pkg::ST_IDLE;
                end
            end
            fca_pkg::ST_IDLE:
            begin
                if (q_valid && q_cmd.op == fca_pkg::OP_CLEAR)
                begin
                    state_next = fca_pkg::ST_CLEAR;
                end
                else if (find_start)
                begin
                    state_next = fca_pkg::ST_CHECK;
                end
            end
            fca_pkg::ST_CHECK:
            begin
                if (!cur_used || wrapped)
                begin
                    state_next = fca_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fca_pkg::ST_CLEAR;
            end
        endcase
    end

    // Sequencer outputs: queue pop, bitmap read address and write enables.
    always_comb
    begin
        q_pop      = 1'b0;
        clr_we     = 1'b0;
        mark_we    = 1'b0;
        find_start = 1'b0;
        find_done  = 1'b0;
        rd_addr    = cursor_reg[fca_pkg::COLOR_W-1:fca_pkg::ROW_SEL_W];
        case (state_reg)
            fca_pkg::ST_CLEAR:
            begin
                clr_we = 1'b1;
            end
            fca_pkg::ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_cmd.op)
                        fca_pkg::OP_CLEAR:
                        begin
                            q_pop = 1'b1;
                        end
                        fca_pkg::OP_MARK:
                        begin
                            q_pop   = 1'b1;
                            mark_we = 1'b1;
                        end
                        fca_pkg::OP_FIND:
                        begin
                            // A find starts only with the result slot free.
                            find_start = !out_valid_reg;
                            q_pop      = !out_valid_reg;
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            fca_pkg::ST_CHECK:
            begin
                // Fetch the row of the next candidate while this one is checked.
                rd_addr   = step_color[fca_pkg::COLOR_W-1:fca_pkg::ROW_SEL_W];
                find_done = !cur_used || wrapped;
            end
            default:
            begin
                clr_we = 1'b0;
            end
        endcase
    end

    // Control registers, cursor and result slot.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fca_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            cursor_reg    <= '0;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == fca_pkg::ST_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            else
            begin
                clr_cnt_reg <= '0;
            end
            if (find_start)
            begin
                start_reg <= cursor_reg;
            end
            if (state_reg == fca_pkg::ST_CHECK && cur_used)
            begin
                // On a full wrap the cursor comes back to the start color.
                cursor_reg <= wrapped ? start_reg : step_color;
            end
            if (find_done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (find_done)
        begin
            out_color_reg <= cur_used ? start_reg : cursor_reg;
            out_found_reg <= !cur_used;
        end
    end

    // Bitmap memory: one row write and one registered row read per cycle.
    always_ff @(posedge clk)
    begin
        if (clr_we)
        begin
            bitmap_mem[clr_cnt_reg] <= '0;
        end
        else if (mark_we)
        begin
            bitmap_mem[q_cmd.color[fca_pkg::COLOR_W-1:fca_pkg::ROW_SEL_W]]
                [q_cmd.color[fca_pkg::ROW_SEL_W-1:0]] <= 1'b1;
        end
        rd_data_reg <= bitmap_mem[rd_addr];
    end

    // A result appears only at the end of a search.
    a_result_from_search: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == fca_pkg::ST_CHECK))
        else $error("result raised outside a search");

    // The queue is drained only by the idle sequencer.
    a_pop_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == fca_pkg::ST_IDLE))
        else $error("queue popped while busy");

    // A search never runs with an undelivered result waiting.
    a_slot_free_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fca_pkg::ST_CHECK) |-> !out_valid_reg)
        else $error("search running with result slot occupied");

    // The clearing pass ends after its last row.
    a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fca_pkg::ST_CLEAR && clr_cnt_reg == LAST_ROW)
        |=> (state_reg == fca_pkg::ST_IDLE))
        else $error("clearing pass did not end");

endmodule

>>> rtl/core/free_color_allocator_unit.sv
// Free color allocator: keeps a presence bitmap over all 24-bit colors and a search
// cursor. Each request carries an operation in s_tuser (clear, mark, find; the unused
// code is accepted and dropped). Requests enter a four-deep queue at one per cycle
// while it has room. Mark is a single bit write to the bitmap memory in the back end.
// Find walks the cursor over candidate colors (stride 97), one bitmap row read per
// visited color; it begins only once the previous result has been taken, and gives
// one result with found in m_tuser. Clear sweeps the bitmap memory one 64-color row a
// cycle; the same sweep runs after reset, and during it queued requests wait while the
// queue still fills.
module free_color_allocator_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [fca_pkg::COLOR_W-1:0]     s_tdata,   // red, green, blue
    input  logic [1:0]                      s_tuser,   // operation
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [fca_pkg::COLOR_W-1:0]     m_tdata,   // free_red, free_green, free_blue
    output logic                            m_tuser    // found
);

    logic           q_full;
    logic           q_push;
    fca_pkg::cmd_t  q_push_cmd;
    logic           q_pop;
    logic           q_valid;
    fca_pkg::cmd_t  q_head_cmd;

    // Front end: handshake and classification.
    fca_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_push_cmd)
    );

    // Command queue between front and back.
    fca_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_head_cmd)
    );

    // Back end: bitmap, cursor search and result slot.
    fca_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_cmd    (q_head_cmd),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule
